### rtl/fps_pkg.sv
// Shared constants, codes and controller/datapath types of the page record store.
package fps_pkg;

  localparam int unsigned PAGE_WORDS    = 1024;
  localparam int unsigned ADDR_W        = $clog2(PAGE_WORDS);
  localparam int unsigned PTR_W         = ADDR_W + 1;
  localparam int unsigned SUM_W         = PTR_W + 1;
  localparam int unsigned MAX_PAY_WORDS = 32;
  localparam int unsigned PAY_IDX_W     = $clog2(MAX_PAY_WORDS);
  localparam int unsigned PAY_CNT_W     = $clog2(MAX_PAY_WORDS + 1);
  localparam int unsigned META_WORDS    = 5;
  localparam int unsigned WORDS_W       = 7;
  localparam int unsigned REQ_W         = 3;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned SIZE_W        = 8;
  localparam int unsigned QUERY_W       = 13;
  localparam int unsigned PADDR_W       = 3;

  localparam logic [31:0] MARKER_RESET   = 32'hA5A5_A5A5;
  localparam logic        REG_IDX_MARKER = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_READ   = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_MODIFY = 3'd3,
    REQ_SIZE   = 3'd4,
    REQ_COUNT  = 3'd5,
    REQ_ERASE  = 3'd6,
    REQ_NONE   = 3'd7
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ABSENT    = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_WORD,
    RES_SIZE,
    RES_COUNT
  } res_kind_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_WALK_START,
    DP_CMP_START,
    DP_RD_P,
    DP_RD_P1,
    DP_RD_P2,
    DP_WALK_REC,
    DP_SKIP,
    DP_CP_READ,
    DP_CP_WRITE,
    DP_TAIL_START,
    DP_FILL_START,
    DP_FILL,
    DP_SET_W,
    DP_WR_WORD,
    DP_RD_START,
    DP_RD_PAY,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e    op;
    status_e   st;
    res_kind_e kind;
  } dp_cmd_t;

  typedef struct packed {
    req_e req;
    logic data_last;
    logic p_lim;
    logic marker_ok;
    logic len_ok;
    logic uid_hit;
    logic found;
    logic copy_last;
    logic fill_done;
    logic wr_last;
    logic rd_last;
    logic words_big;
    logic add_full;
    logic mod_full;
    logic rd_big;
    logic words_zero;
    logic out_busy;
  } dp_stat_t;

endpackage

### rtl/fps_req_if.sv
// Request channel: valid/ready handshake with the request payload.
interface fps_req_if;
  import fps_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [31:0]         uid;
  logic [SIZE_W-1:0]   size_bytes;
  logic [31:0]         data_word;
  logic                data_last;

  modport source (output valid, req_type, uid, size_bytes, data_word, data_last,
                  input ready);
  modport sink (input valid, req_type, uid, size_bytes, data_word, data_last,
                output ready);
endinterface

### rtl/fps_rsp_if.sv
// Result channel: valid/ready handshake with the result payload.
interface fps_rsp_if;
  import fps_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [31:0]         read_word;
  logic [QUERY_W-1:0]  query_value;
  logic                result_last;

  modport source (output valid, status, read_word, query_value, result_last,
                  input ready);
  modport sink (input valid, status, read_word, query_value, result_last,
                output ready);
endinterface

### rtl/fps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/fps_ctrl.sv
// Request sequencer: chain walk, compaction, record write, read-out and erase control.
module fps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  fps_pkg::dp_stat_t stat_i,
  output fps_pkg::dp_cmd_t  cmd_o
);
  import fps_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_W0,
    S_W1,
    S_W2,
    S_W3,
    S_CP_RD,
    S_CP_WR,
    S_WALK_END,
    S_FILL,
    S_WREC,
    S_RD_ISSUE,
    S_RD_CAP,
    S_EMIT
  } state_e;

  state_e    state_q, state_d;
  logic      compact_q, compact_d;
  status_e   st_q, st_d;
  res_kind_e kind_q, kind_d;

  always_comb begin
    state_d     = state_q;
    compact_d   = compact_q;
    st_d        = st_q;
    kind_d      = kind_q;
    req_ready_o = 1'b0;
    cmd_o       = '{op: DP_NOP, st: ST_OK, kind: RES_PLAIN};
    case (state_q)
      S_CLEAR: begin
        if (stat_i.fill_done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = DP_FILL;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = DP_ACCEPT;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        compact_d = 1'b0;
        case (stat_i.req)
          REQ_NONE: state_d = S_IDLE;
          REQ_ADD, REQ_MODIFY: begin
            if (!stat_i.data_last) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.op = DP_WALK_START;
              state_d  = S_W0;
            end
          end
          REQ_ERASE: begin
            cmd_o.op = DP_FILL_START;
            state_d  = S_FILL;
          end
          default: begin
            cmd_o.op = DP_WALK_START;
            state_d  = S_W0;
          end
        endcase
      end
      S_W0: begin
        if (stat_i.p_lim) begin
          state_d = S_WALK_END;
        end else begin
          cmd_o.op = DP_RD_P;
          state_d  = S_W1;
        end
      end
      S_W1: begin
        cmd_o.op = DP_RD_P1;
        state_d  = stat_i.marker_ok ? S_W2 : S_WALK_END;
      end
      S_W2: begin
        cmd_o.op = DP_RD_P2;
        state_d  = stat_i.len_ok ? S_W3 : S_WALK_END;
      end
      S_W3: begin
        if (!compact_q) begin
          cmd_o.op = DP_WALK_REC;
          state_d  = S_W0;
        end else if (stat_i.uid_hit) begin
          cmd_o.op = DP_SKIP;
          state_d  = S_W0;
        end else begin
          state_d = S_CP_RD;
        end
      end
      S_CP_RD: begin
        cmd_o.op = DP_CP_READ;
        state_d  = S_CP_WR;
      end
      S_CP_WR: begin
        cmd_o.op = DP_CP_WRITE;
        state_d  = stat_i.copy_last ? S_W0 : S_CP_RD;
      end
      S_WALK_END: begin
        state_d = S_EMIT;
        kind_d  = RES_PLAIN;
        st_d    = ST_OK;
        if (compact_q) begin
          cmd_o.op = DP_TAIL_START;
          state_d  = S_FILL;
        end else begin
          case (stat_i.req)
            REQ_ADD: begin
              if (stat_i.found) st_d = ST_PRESENT;
              else if (stat_i.words_big) st_d = ST_TOO_LARGE;
              else if (stat_i.add_full) st_d = ST_FULL;
              else begin
                cmd_o.op = DP_SET_W;
                state_d  = S_WREC;
              end
            end
            REQ_MODIFY: begin
              if (!stat_i.found) st_d = ST_ABSENT;
              else if (stat_i.words_big) st_d = ST_TOO_LARGE;
              else if (stat_i.mod_full) st_d = ST_FULL;
              else begin
                cmd_o.op  = DP_CMP_START;
                compact_d = 1'b1;
                state_d   = S_W0;
              end
            end
            REQ_READ: begin
              if (!stat_i.found) st_d = ST_ABSENT;
              else if (stat_i.rd_big) st_d = ST_TOO_LARGE;
              else if (!stat_i.words_zero) begin
                cmd_o.op = DP_RD_START;
                state_d  = S_RD_ISSUE;
              end
            end
            REQ_DELETE: begin
              if (!stat_i.found) st_d = ST_ABSENT;
              else begin
                cmd_o.op  = DP_CMP_START;
                compact_d = 1'b1;
                state_d   = S_W0;
              end
            end
            REQ_SIZE: begin
              if (!stat_i.found) st_d = ST_ABSENT;
              else kind_d = RES_SIZE;
            end
            REQ_COUNT: kind_d = RES_COUNT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        if (!stat_i.fill_done) begin
          cmd_o.op = DP_FILL;
        end else if (compact_q && stat_i.req == REQ_MODIFY) begin
          state_d = S_WREC;
        end else begin
          st_d    = ST_OK;
          kind_d  = RES_PLAIN;
          state_d = S_EMIT;
        end
      end
      S_WREC: begin
        cmd_o.op = DP_WR_WORD;
        if (stat_i.wr_last) begin
          st_d    = ST_OK;
          kind_d  = RES_PLAIN;
          state_d = S_EMIT;
        end
      end
      S_RD_ISSUE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = DP_RD_PAY;
          state_d  = S_RD_CAP;
        end
      end
      S_RD_CAP: begin
        cmd_o   = '{op: DP_EMIT, st: ST_OK, kind: RES_WORD};
        state_d = stat_i.rd_last ? S_IDLE : S_RD_ISSUE;
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o   = '{op: DP_EMIT, st: st_q, kind: kind_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      compact_q <= 1'b0;
      st_q      <= ST_OK;
      kind_q    <= RES_PLAIN;
    end else begin
      state_q   <= state_d;
      compact_q <= compact_d;
      st_q      <= st_d;
      kind_q    <= kind_d;
    end
  end
endmodule

### rtl/fps_dp.sv
// Datapath: page memory, payload buffer, walk pointers, marker register and result register.
module fps_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fps_pkg::dp_cmd_t             cmd_i,
  output fps_pkg::dp_stat_t            stat_o,
  input  logic [fps_pkg::REQ_W-1:0]    req_type_i,
  input  logic [31:0]                  uid_i,
  input  logic [fps_pkg::SIZE_W-1:0]   size_bytes_i,
  input  logic [31:0]                  data_word_i,
  input  logic                         data_last_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output logic [fps_pkg::STATUS_W-1:0] status_o,
  output logic [31:0]                  read_word_o,
  output logic [fps_pkg::QUERY_W-1:0]  query_value_o,
  output logic                         result_last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fps_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import fps_pkg::*;

  function automatic logic [31:0] tail_mask(logic last, logic [1:0] rem);
    logic [31:0] m;
    m = '1;
    if (last) begin
      case (rem)
        2'd1: m = 32'h0000_00FF;
        2'd2: m = 32'h0000_FFFF;
        2'd3: m = 32'h00FF_FFFF;
        default: m = '1;
      endcase
    end
    return m;
  endfunction

  logic [31:0]         marker_q;
  logic [31:0]         uid_q;
  logic [SIZE_W-1:0]   sz_q;
  req_e                req_q;
  logic                dl_q;
  logic [PTR_W-1:0]    p_q, w_q, k_q, n_q, s_q, len_q, flen_q;
  logic [ADDR_W-1:0]   at_q;
  logic                found_q;
  logic [31:0]         pay_buf_q [MAX_PAY_WORDS];
  logic [PAY_CNT_W-1:0] pay_cnt_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [31:0]         out_word_q;
  logic [QUERY_W-1:0]  out_query_q;
  logic                out_last_q;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [31:0]         ram_wdata, rdata;

  logic [SIZE_W:0]     sz_plus3;
  logic [WORDS_W-1:0]  words;
  logic [SUM_W-1:0]    add_sum, mod_sum;
  logic [QUERY_W-1:0]  rec_bytes;
  logic [PTR_W-1:0]    pay_addr;
  logic [PAY_IDX_W-1:0] pidx;
  logic [31:0]         pay_val, rec_word;
  logic                rd_last, wr_last, uid_hit, copy_last, cfg_wr;

  fps_ram #(.WIDTH(32), .DEPTH(PAGE_WORDS)) u_page (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign sz_plus3  = {1'b0, sz_q} + (SIZE_W+1)'(3);
  assign words     = sz_plus3[SIZE_W:2];
  assign add_sum   = SUM_W'(p_q) + SUM_W'(META_WORDS) + SUM_W'(words);
  assign mod_sum   = SUM_W'(p_q) - SUM_W'(s_q) + SUM_W'(META_WORDS) + SUM_W'(words);
  assign rec_bytes = (QUERY_W'(flen_q) - QUERY_W'(META_WORDS)) << 2;
  assign rd_last   = (k_q + PTR_W'(1)) == PTR_W'(words);
  assign wr_last   = k_q == (PTR_W'(words) + PTR_W'(META_WORDS - 1));
  assign uid_hit   = rdata == uid_q;
  assign copy_last = k_q == (len_q - PTR_W'(1));
  assign pay_addr  = PTR_W'(at_q) + PTR_W'(META_WORDS) + k_q;

  assign pidx    = PAY_IDX_W'(k_q - PTR_W'(META_WORDS));
  assign pay_val = (PAY_CNT_W'(pidx) < pay_cnt_q) ? pay_buf_q[pidx] : '0;

  always_comb begin
    if (k_q == PTR_W'(0)) rec_word = marker_q;
    else if (k_q == PTR_W'(1)) rec_word = 32'(META_WORDS) + 32'(words);
    else if (k_q == PTR_W'(2)) rec_word = uid_q;
    else if (k_q < PTR_W'(META_WORDS)) rec_word = '0;
    else rec_word = pay_val & tail_mask(wr_last, sz_q[1:0]);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_q[ADDR_W-1:0] + k_q[ADDR_W-1:0];
    ram_wdata = rec_word;
    ram_raddr = p_q[ADDR_W-1:0];
    case (cmd_i.op)
      DP_RD_P1:    ram_raddr = p_q[ADDR_W-1:0] + ADDR_W'(1);
      DP_RD_P2:    ram_raddr = p_q[ADDR_W-1:0] + ADDR_W'(2);
      DP_CP_READ:  ram_raddr = p_q[ADDR_W-1:0] + k_q[ADDR_W-1:0];
      DP_RD_PAY:   ram_raddr = pay_addr[ADDR_W-1:0];
      DP_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = p_q[ADDR_W-1:0];
        ram_wdata = '1;
      end
      DP_CP_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = rdata;
      end
      DP_WR_WORD:  ram_we = 1'b1;
      default:     ram_raddr = p_q[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    stat_o.req        = req_q;
    stat_o.data_last  = dl_q;
    stat_o.p_lim      = p_q > PTR_W'(PAGE_WORDS - META_WORDS);
    stat_o.marker_ok  = rdata == marker_q;
    stat_o.len_ok     = (rdata >= 32'(META_WORDS)) &&
                        (rdata <= (32'(PAGE_WORDS) - 32'(p_q)));
    stat_o.uid_hit    = uid_hit;
    stat_o.found      = found_q;
    stat_o.copy_last  = copy_last;
    stat_o.fill_done  = p_q == PTR_W'(PAGE_WORDS);
    stat_o.wr_last    = wr_last;
    stat_o.rd_last    = rd_last;
    stat_o.words_big  = words > WORDS_W'(MAX_PAY_WORDS);
    stat_o.add_full   = add_sum > SUM_W'(PAGE_WORDS);
    stat_o.mod_full   = mod_sum > SUM_W'(PAGE_WORDS);
    stat_o.rd_big     = QUERY_W'(sz_q) > rec_bytes;
    stat_o.words_zero = words == '0;
    stat_o.out_busy   = out_valid_q;
  end

  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_IDX_MARKER);
  assign prdata = (paddr[PADDR_W-1] == REG_IDX_MARKER) ? marker_q : '0;
  assign pready = 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_ACCEPT && (req_e'(req_type_i) == REQ_ADD ||
        req_e'(req_type_i) == REQ_MODIFY) && pay_cnt_q < PAY_CNT_W'(MAX_PAY_WORDS)) begin
      pay_buf_q[pay_cnt_q[PAY_IDX_W-1:0]] <= data_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q     <= MARKER_RESET;
      uid_q        <= '0;
      sz_q         <= '0;
      req_q        <= REQ_NONE;
      dl_q         <= 1'b0;
      p_q          <= '0;
      w_q          <= '0;
      k_q          <= '0;
      n_q          <= '0;
      s_q          <= '0;
      len_q        <= '0;
      flen_q       <= '0;
      at_q         <= '0;
      found_q      <= 1'b0;
      pay_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_word_q   <= '0;
      out_query_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        marker_q <= pwdata;
      end
      if (out_valid_q && rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        DP_ACCEPT: begin
          uid_q <= uid_i;
          sz_q  <= size_bytes_i;
          req_q <= req_e'(req_type_i);
          dl_q  <= data_last_i;
          if (req_e'(req_type_i) == REQ_ADD || req_e'(req_type_i) == REQ_MODIFY) begin
            if (pay_cnt_q < PAY_CNT_W'(MAX_PAY_WORDS)) begin
              pay_cnt_q <= pay_cnt_q + PAY_CNT_W'(1);
            end
          end else if (req_e'(req_type_i) != REQ_NONE) begin
            pay_cnt_q <= '0;
          end
        end
        DP_WALK_START: begin
          p_q     <= '0;
          n_q     <= '0;
          s_q     <= '0;
          found_q <= 1'b0;
        end
        DP_CMP_START: begin
          p_q <= '0;
          w_q <= '0;
        end
        DP_RD_P2: begin
          len_q <= rdata[PTR_W-1:0];
          k_q   <= '0;
        end
        DP_WALK_REC: begin
          n_q <= n_q + PTR_W'(1);
          p_q <= p_q + len_q;
          if (uid_hit) begin
            s_q <= s_q + len_q;
            if (!found_q) begin
              found_q <= 1'b1;
              at_q    <= p_q[ADDR_W-1:0];
              flen_q  <= len_q;
            end
          end
        end
        DP_SKIP: p_q <= p_q + len_q;
        DP_CP_WRITE: begin
          if (copy_last) begin
            w_q <= w_q + len_q;
            p_q <= p_q + len_q;
            k_q <= '0;
          end else begin
            k_q <= k_q + PTR_W'(1);
          end
        end
        DP_TAIL_START: begin
          p_q <= w_q;
          k_q <= '0;
        end
        DP_FILL_START: p_q <= '0;
        DP_FILL:       p_q <= p_q + PTR_W'(1);
        DP_SET_W: begin
          w_q <= p_q;
          k_q <= '0;
        end
        DP_WR_WORD:  k_q <= k_q + PTR_W'(1);
        DP_RD_START: k_q <= '0;
        DP_EMIT: begin
          out_valid_q  <= 1'b1;
          out_status_q <= cmd_i.st;
          pay_cnt_q    <= '0;
          out_word_q   <= '0;
          out_query_q  <= '0;
          out_last_q   <= 1'b1;
          case (cmd_i.kind)
            RES_WORD: begin
              out_word_q <= rdata & tail_mask(rd_last, sz_q[1:0]);
              out_last_q <= rd_last;
              k_q        <= k_q + PTR_W'(1);
            end
            RES_SIZE:  out_query_q <= rec_bytes;
            RES_COUNT: out_query_q <= QUERY_W'(n_q);
            default:   out_query_q <= '0;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign rsp_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_word_o   = out_word_q;
  assign query_value_o = out_query_q;
  assign result_last_o = out_last_q;
endmodule

### rtl/flash_page_record_store_unit.sv
// Top level of the page record store: sequencer, datapath and assertions.
//
//  port        dir   protocol      carries
//  req_i       in    valid/ready   req_type, uid, size_bytes, data_word, data_last
//  rsp_o       out   valid/ready   status, read_word, query_value, result_last
//  APB         in    psel/penable  record_marker at byte address 0
//
// After reset the page is swept to ones, one word a cycle, before the first request
// is taken. A payload word with data_last low is only buffered. Other requests,
// erase and REQ_NONE apart, walk the record chain (states S_W0 to S_W3 per record)
// on the single page memory read port; compaction copies each kept word by a read
// and a write state, then erases the tail; erase sweeps the page; a record is written
// one word a cycle. A stalled result holds the sequencer before its next transfer.
module flash_page_record_store_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fps_req_if.sink                     req_i,
  fps_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (req_i.req_type),
    .uid_i         (req_i.uid),
    .size_bytes_i  (req_i.size_bytes),
    .data_word_i   (req_i.data_word),
    .data_last_i   (req_i.data_last),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .read_word_o   (rsp_o.read_word),
    .query_value_o (rsp_o.query_value),
    .result_last_o (rsp_o.result_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_EMIT) |-> !stat.out_busy)
    else $error("result overwritten before transfer");

  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while previous one in progress");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_FILL) |-> !stat.fill_done)
    else $error("fill beyond page end");

  a_rec_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_WR_WORD) |-> !stat.words_big)
    else $error("record write with oversize payload");
endmodule

### tb/sv/flash_page_record_store_unit_test.sv
// Testbench for the page record store: directed and random requests checked against a predictor.
module flash_page_record_store_unit_test;
  import fps_pkg::*;

  typedef struct packed {
    status_e     st;
    logic [31:0] word;
    logic [12:0] qval;
    logic        last;
  } rsp_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  fps_req_if req_bus ();
  fps_rsp_if rsp_bus ();

  flash_page_record_store_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [31:0] page_mem [PAGE_WORDS];
  logic [31:0] pay_buf [MAX_PAY_WORDS];
  int unsigned pay_cnt;
  logic [31:0] marker_q;

  rsp_t        rsp_q[$];
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_mismatch;
  int unsigned hold_cycles;
  logic [31:0] uid_pool [8];
  int unsigned st_seen [5];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic int unsigned rec_len(int unsigned p);
    int unsigned len;
    if (p > PAGE_WORDS - META_WORDS) return 0;
    if (page_mem[p] != marker_q) return 0;
    len = page_mem[p + 1];
    if (len < META_WORDS || len > PAGE_WORDS - p) return 0;
    return len;
  endfunction

  function automatic int unsigned chain_walk(logic [31:0] uid, output int unsigned cnt,
                                             output bit found, output int unsigned at);
    int unsigned p;
    int unsigned len;
    p = 0; cnt = 0; found = 0; at = 0;
    len = rec_len(p);
    while (len != 0) begin
      if (!found && page_mem[p + 2] == uid) begin
        found = 1; at = p;
      end
      cnt++;
      p += len;
      len = rec_len(p);
    end
    return p;
  endfunction

  function automatic logic [31:0] tail_mask(int unsigned idx, int unsigned words,
                                            int unsigned size);
    int unsigned rem;
    rem = size & 3;
    if (idx + 1 == words && rem != 0) return (32'h1 << (rem * 8)) - 1;
    return '1;
  endfunction

  function automatic int unsigned compact_out(logic [31:0] uid);
    int unsigned r;
    int unsigned w;
    int unsigned len;
    r = 0; w = 0;
    len = rec_len(r);
    while (len != 0) begin
      if (page_mem[r + 2] != uid) begin
        for (int unsigned i = 0; i < len; i++) page_mem[w + i] = page_mem[r + i];
        w += len;
      end
      r += len;
      len = rec_len(r);
    end
    for (int unsigned i = w; i < PAGE_WORDS; i++) page_mem[i] = '1;
    return w;
  endfunction

  function automatic int unsigned uid_words(logic [31:0] uid);
    int unsigned p;
    int unsigned s;
    int unsigned len;
    p = 0; s = 0;
    len = rec_len(p);
    while (len != 0) begin
      if (page_mem[p + 2] == uid) s += len;
      p += len;
      len = rec_len(p);
    end
    return s;
  endfunction

  function automatic void store_record(int unsigned pos, logic [31:0] uid, int unsigned size);
    int unsigned words;
    words = (size + 3) / 4;
    page_mem[pos]     = marker_q;
    page_mem[pos + 1] = META_WORDS + words;
    page_mem[pos + 2] = uid;
    page_mem[pos + 3] = '0;
    page_mem[pos + 4] = '0;
    for (int unsigned i = 0; i < words; i++)
      page_mem[pos + META_WORDS + i] =
        ((i < pay_cnt) ? pay_buf[i] : 32'h0) & tail_mask(i, words, size);
  endfunction

  function automatic void push_rsp(status_e st, logic [31:0] word, int unsigned qv, bit last);
    rsp_t r;
    r.st = st; r.word = word; r.qval = qv[12:0]; r.last = last;
    rsp_q.push_back(r);
    st_seen[st]++;
  endfunction

  function automatic void predict_req(req_e rq, logic [31:0] uid, int unsigned sz,
                                      logic [31:0] dw, bit dl);
    int unsigned cnt;
    int unsigned at;
    int unsigned eor;
    int unsigned len;
    int unsigned words;
    bit found;
    status_e st;
    if (rq == REQ_NONE) return;
    if (rq == REQ_ADD || rq == REQ_MODIFY) begin
      if (pay_cnt < MAX_PAY_WORDS) begin
        pay_buf[pay_cnt] = dw;
        pay_cnt++;
      end
      if (!dl) return;
      eor = chain_walk(uid, cnt, found, at);
      words = (sz + 3) / 4;
      if (rq == REQ_ADD) begin
        if (found) st = ST_PRESENT;
        else if (words > MAX_PAY_WORDS) st = ST_TOO_LARGE;
        else if (eor + META_WORDS + words > PAGE_WORDS) st = ST_FULL;
        else begin
          store_record(eor, uid, sz);
          st = ST_OK;
        end
      end else begin
        if (!found) st = ST_ABSENT;
        else if (words > MAX_PAY_WORDS) st = ST_TOO_LARGE;
        else if (eor - uid_words(uid) + META_WORDS + words > PAGE_WORDS) st = ST_FULL;
        else begin
          store_record(compact_out(uid), uid, sz);
          st = ST_OK;
        end
      end
      pay_cnt = 0;
      push_rsp(st, '0, 0, 1);
      return;
    end
    pay_cnt = 0;
    eor = chain_walk(uid, cnt, found, at);
    case (rq)
      REQ_READ: begin
        if (!found) push_rsp(ST_ABSENT, '0, 0, 1);
        else begin
          len = page_mem[at + 1];
          words = (sz + 3) / 4;
          if (sz > (len - META_WORDS) * 4) push_rsp(ST_TOO_LARGE, '0, 0, 1);
          else if (words == 0) push_rsp(ST_OK, '0, 0, 1);
          else
            for (int unsigned i = 0; i < words; i++)
              push_rsp(ST_OK, page_mem[at + META_WORDS + i] & tail_mask(i, words, sz), 0,
                       i + 1 == words);
        end
      end
      REQ_DELETE: begin
        if (!found) push_rsp(ST_ABSENT, '0, 0, 1);
        else begin
          void'(compact_out(uid));
          push_rsp(ST_OK, '0, 0, 1);
        end
      end
      REQ_SIZE: begin
        if (!found) push_rsp(ST_ABSENT, '0, 0, 1);
        else push_rsp(ST_OK, '0, (page_mem[at + 1] - META_WORDS) * 4, 1);
      end
      REQ_COUNT: push_rsp(ST_OK, '0, cnt, 1);
      default: begin
        for (int unsigned i = 0; i < PAGE_WORDS; i++) page_mem[i] = '1;
        push_rsp(ST_OK, '0, 0, 1);
      end
    endcase
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      n_results++;
      if (rsp_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("ERROR: unexpected result status=%0d word=%h q=%0d last=%b",
                   rsp_bus.status, rsp_bus.read_word, rsp_bus.query_value,
                   rsp_bus.result_last);
      end else begin
        e = rsp_q.pop_front();
        if (rsp_bus.status !== e.st || rsp_bus.read_word !== e.word ||
            rsp_bus.query_value !== e.qval || rsp_bus.result_last !== e.last) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"ERROR: result exp st=%0d word=%h q=%0d last=%b, ",
                      "got st=%0d word=%h q=%0d last=%b"},
                     e.st, e.word, e.qval, e.last, rsp_bus.status, rsp_bus.read_word,
                     rsp_bus.query_value, rsp_bus.result_last);
        end
      end
    end
  end

  // ---------------- result receiver ----------------
  initial begin
    int unsigned stall;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
        if (stall > 0) begin
          rsp_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_bus.valid);
    end
  end

  // ---------------- drivers ----------------
  task automatic send_req(req_e rq, logic [31:0] uid, int unsigned sz, logic [31:0] dw,
                          bit dl);
    int unsigned gap;
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= rq;
    req_bus.uid        <= uid;
    req_bus.size_bytes <= sz[SIZE_W-1:0];
    req_bus.data_word  <= dw;
    req_bus.data_last  <= dl;
    do @(posedge clk_i); while (!req_bus.ready);
    predict_req(rq, uid, sz[SIZE_W-1:0], dw, dl);
    n_items++;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_record(req_e rq, logic [31:0] uid, int unsigned sz, int unsigned nw);
    for (int unsigned i = 0; i < nw; i++)
      send_req(rq, uid, sz, $urandom(), i + 1 == nw);
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_marker(logic [31:0] val);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_IDX_MARKER) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    marker_q = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== val) begin
      n_mismatch++;
      if (n_mismatch <= 10) $display("ERROR: marker readback exp %h got %h", val, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    send_req(REQ_COUNT, 32'h0, 0, '0, 0);
    send_req(REQ_READ, 32'h1234, 4, '0, 0);
    send_req(REQ_SIZE, 32'h1234, 0, '0, 0);
    send_req(REQ_DELETE, 32'h1234, 0, '0, 0);
    send_req(REQ_MODIFY, 32'h1234, 4, 32'hDEAD_BEEF, 1);
    send_req(REQ_ADD, 32'h0, 0, 32'hFFFF_FFFF, 1);
    send_record(REQ_ADD, 32'hFFFF_FFFF, 128, 34);
    send_req(REQ_ADD, 32'h0, 4, 32'h1, 1);
    send_req(REQ_ADD, 32'h55, 129, 32'h2, 1);
    send_req(REQ_ADD, 32'h56, 255, 32'h3, 1);
    send_req(REQ_READ, 32'h0, 0, '0, 0);
    send_req(REQ_READ, 32'hFFFF_FFFF, 128, '0, 0);
    send_req(REQ_READ, 32'hFFFF_FFFF, 129, '0, 0);
    send_req(REQ_READ, 32'hFFFF_FFFF, 5, '0, 0);
    send_req(REQ_SIZE, 32'hFFFF_FFFF, 0, '0, 0);
    // partial payload kept across a REQ_NONE, then dropped by a count request
    send_req(REQ_ADD, 32'h77, 8, 32'hAAAA_5555, 0);
    send_req(REQ_NONE, 32'h77, 8, 32'h0, 1);
    send_req(REQ_COUNT, 32'h77, 0, '0, 0);
    send_req(REQ_MODIFY, 32'hFFFF_FFFF, 7, 32'h8765_4321, 1);
    send_req(REQ_READ, 32'hFFFF_FFFF, 7, '0, 0);
    send_req(REQ_DELETE, 32'h0, 0, '0, 0);
    send_req(REQ_COUNT, 32'h0, 0, '0, 0);
    send_req(REQ_ERASE, 32'h0, 0, '0, 0);
    send_req(REQ_COUNT, 32'h0, 0, '0, 0);
  endtask

  task automatic test_page_full();
    for (int unsigned i = 0; i < 30; i++)
      send_record(REQ_ADD, 32'h100 + i, 128, $urandom_range(1, 2));
    send_record(REQ_MODIFY, 32'h100, 128, 1);
    send_req(REQ_COUNT, 32'h0, 0, '0, 0);
    send_req(REQ_DELETE, 32'h101, 0, '0, 0);
    send_record(REQ_MODIFY, 32'h100, 128, 2);
    send_req(REQ_ERASE, 32'h0, 0, '0, 0);
  endtask

  task automatic test_marker();
    logic [31:0] vals [3];
    vals[0] = 32'h0;
    vals[1] = 32'hFFFF_FFFF;
    vals[2] = $urandom();
    foreach (vals[k]) begin
      write_marker(vals[k]);
      send_req(REQ_COUNT, 32'h0, 0, '0, 0);
      send_record(REQ_ADD, 32'h9, 8, 2);
      send_record(REQ_ADD, 32'hA, 4, 1);
      send_req(REQ_READ, 32'h9, 8, '0, 0);
      send_req(REQ_COUNT, 32'h0, 0, '0, 0);
    end
    // records written under the last marker are not chained after the change back
    write_marker(MARKER_RESET);
    send_req(REQ_COUNT, 32'h0, 0, '0, 0);
    send_req(REQ_ERASE, 32'h0, 0, '0, 0);
  endtask

  task automatic test_backpressure();
    send_record(REQ_ADD, 32'h42, 128, 3);
    hold_cycles = 3000;
    for (int unsigned i = 0; i < 12; i++) send_req(REQ_READ, 32'h42, 128, '0, 0);
    send_req(REQ_DELETE, 32'h42, 0, '0, 0);
  endtask

  task automatic test_random();
    int unsigned stop;
    int unsigned k;
    int unsigned sz;
    int unsigned nw;
    logic [31:0] uid;
    stop = n_items + 236;
    while (n_items < stop) begin
      k   = $urandom_range(0, 99);
      uid = ($urandom_range(0, 9) == 0) ? $urandom() : uid_pool[$urandom_range(0, 7)];
      case ($urandom_range(0, 19))
        0:       sz = $urandom_range(129, 255);
        1, 2, 3: sz = $urandom_range(100, 128);
        default: sz = $urandom_range(0, 24);
      endcase
      nw = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 34) : ((sz + 3) / 4 > 0 ?
           ((sz + 3) / 4 > 34 ? 34 : (sz + 3) / 4) : 1);
      if (k < 35) send_record(REQ_ADD, uid, sz, nw);
      else if (k < 50) send_record(REQ_MODIFY, uid, sz, nw);
      else if (k < 68) send_req(REQ_READ, uid, sz, $urandom(), $urandom_range(0, 1));
      else if (k < 76) send_req(REQ_DELETE, uid, sz, $urandom(), $urandom_range(0, 1));
      else if (k < 84) send_req(REQ_SIZE, uid, sz, $urandom(), $urandom_range(0, 1));
      else if (k < 90) send_req(REQ_COUNT, uid, sz, $urandom(), $urandom_range(0, 1));
      else if (k < 92) send_req(REQ_ERASE, uid, sz, $urandom(), $urandom_range(0, 1));
      else if (k < 94) send_req(REQ_NONE, uid, sz, $urandom(), $urandom_range(0, 1));
      else if (k < 97) begin
        // broken stream: payload words with data_last low, then whatever request comes next
        for (int unsigned i = 0; i < $urandom_range(1, 3); i++)
          send_req($urandom_range(0, 1) ? REQ_ADD : REQ_MODIFY, uid, sz, $urandom(), 0);
      end else send_record(REQ_ADD, $urandom(), sz, nw);
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= REQ_NONE;
    req_bus.uid        <= '0;
    req_bus.size_bytes <= '0;
    req_bus.data_word  <= '0;
    req_bus.data_last  <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    for (int unsigned i = 0; i < PAGE_WORDS; i++) page_mem[i] = '1;
    foreach (pay_buf[i]) pay_buf[i] = '0;
    pay_cnt     = 0;
    marker_q    = MARKER_RESET;
    n_items     = 0;
    n_results   = 0;
    n_mismatch  = 0;
    hold_cycles = 0;
    foreach (st_seen[i]) st_seen[i] = 0;
    foreach (uid_pool[i]) uid_pool[i] = $urandom();
    uid_pool[0] = 32'h0;
    uid_pool[1] = 32'hFFFF_FFFF;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_page_full();
    test_marker();
    test_backpressure();
    test_random();

    req_bus.valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk_i);
    repeat (2100) @(posedge clk_i);

    $display("Covered %0d request transfers and %0d result transfers, marker values 0, all ones,",
             n_items, n_results);
    $display("random and reset; statuses ok/absent/present/large/full: %0d/%0d/%0d/%0d/%0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
    if (n_mismatch == 0 && rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("ERROR: %0d mismatches, %0d results outstanding", n_mismatch, rsp_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
